// File: rtl/gfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared widths, register codes, sequencer states and control types for the
// anisotropy block.
// ----------------------------------------------------------------------------
package gfa_pkg;

	localparam int COEF_W     = 16;
	localparam int SQ_W       = 32;
	localparam int SUM_W      = 40;
	localparam int IDX_W      = 7;
	localparam int VAL_W      = 24;
	localparam int CMP_W      = 41;
	localparam int XR_W       = 48;
	localparam int CNT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;

	localparam logic [IDX_W-1:0] LIMIT_RESET = 7'd45;
	localparam logic [IDX_W-1:0] IDX_MAX     = 7'd127;

	localparam logic [CNT_W-1:0] DIV_STEPS_M1  = 6'd32;
	localparam logic [CNT_W-1:0] SQRT_STEPS_M1 = 6'd23;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADD  = 6'b000010,
		S_PREP = 6'b000100,
		S_DIV  = 6'b001000,
		S_SQRT = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic take;
		logic add;
		logic sq_c0;
		logic clear;
	} acc_ctrl_t;

endpackage

// File: rtl/gfa_sub_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_sub_unit
// Shared compare and subtract used by every divide and square root step.
// ----------------------------------------------------------------------------
module gfa_sub_unit (
	input  logic [gfa_pkg::CMP_W-1:0] a,
	input  logic [gfa_pkg::CMP_W-1:0] b,
	output logic                      ge,
	output logic [gfa_pkg::CMP_W-1:0] diff
);
	import gfa_pkg::*;

	logic [CMP_W:0] full;

	// borrow out of the extended subtract gives the compare
	assign full = {1'b0, a} - {1'b0, b};
	assign ge   = ~full[CMP_W];
	assign diff = full[CMP_W-1:0];

endmodule

// File: rtl/gfa_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_accum
// Squares each coefficient, keeps the voxel's first coefficient, the item
// count and the running sum of squares.
// ----------------------------------------------------------------------------
module gfa_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gfa_pkg::acc_ctrl_t         ctrl,
	input  logic [gfa_pkg::COEF_W-1:0] coefficient,
	input  logic [gfa_pkg::IDX_W-1:0]  stop,
	output logic [gfa_pkg::SUM_W-1:0]  sum,
	output logic [gfa_pkg::SQ_W-1:0]   square
);
	import gfa_pkg::*;

	logic [SUM_W-1:0]  sum_q;
	logic [COEF_W-1:0] c0_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SQ_W-1:0]   sq_s1;
	logic              use_s1;

	logic signed [COEF_W-1:0] mul_in;
	logic signed [SQ_W-1:0]   product;

	// the multiplier squares the incoming word, or c0 at voxel end
	assign mul_in  = ctrl.sq_c0 ? $signed(c0_q) : $signed(coefficient);
	assign product = mul_in * mul_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			c0_q   <= '0;
			idx_q  <= '0;
			use_s1 <= 1'b0;
		end else if (ctrl.clear) begin
			sum_q  <= '0;
			c0_q   <= '0;
			idx_q  <= '0;
			use_s1 <= 1'b0;
		end else begin
			if (ctrl.take) begin
				if (idx_q == '0) begin
					c0_q <= coefficient;
				end
				use_s1 <= (idx_q < stop);
				if (idx_q != IDX_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (ctrl.add && use_s1) begin
				sum_q <= sum_q + {{(SUM_W-SQ_W){1'b0}}, sq_s1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take || ctrl.sq_c0) begin
			sq_s1 <= product;
		end
	end

	assign sum    = sum_q;
	assign square = sq_s1;

endmodule

// File: rtl/gfa_from_sh_coefficients.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_from_sh_coefficients
// Generalized fractional anisotropy or l2 norm of one voxel's harmonic
// coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed Q3.12 coefficient per word, s_tlast closes the voxel.
//   m_* gives one word per voxel: unsigned Q8.16 value, tuser = zero energy.
//   cfg_* writes mode (index 0, 0 = gfa, 1 = norm) and coeff_limit (index 1).
// Sequence:
//   each coefficient is squared in the multiplier, then added into the
//   40-bit sum; the input is not ready during the add.
//   after the last coefficient the shared subtractor runs the voxel end:
//   prep, 33 divide steps (gfa mode only), 24 root steps and output, or
//   prep and output for zero energy; the input is not ready meanwhile.
//   the result sits in an output register; the next voxel is taken while it
//   waits, and a second result waits in the sequencer until m_tready.
// Reset:
//   arst_n clears the voxel state, mode = gfa, coeff_limit = 45.
// ----------------------------------------------------------------------------
module gfa_from_sh_coefficients #(
	parameter int MAX_COEFFS = 45
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// coefficient
	input  logic [gfa_pkg::COEF_W-1:0]     s_tdata,
	input  logic                           s_tlast,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// value
	output logic [gfa_pkg::VAL_W-1:0]      m_tdata,
	// energy_zero
	output logic                           m_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gfa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gfa_pkg::*;

	localparam logic [IDX_W-1:0] MaxCoeffs = IDX_W'(MAX_COEFFS);

	state_t state_q;

	logic             mode_q;
	logic [IDX_W-1:0] limit_q;
	logic [IDX_W-1:0] stop;

	acc_ctrl_t        acc_ctrl;
	logic [SUM_W-1:0] sum;
	logic [SQ_W-1:0]  square;

	logic             last_q;
	logic [SUM_W-1:0] rem_q;
	logic [XR_W-1:0]  x_q;
	logic [VAL_W-1:0] root_q;
	logic             zero_q;
	logic [CNT_W-1:0] cnt_q;

	logic [VAL_W-1:0] out_value_q;
	logic             out_zero_q;
	logic             out_valid_q;

	logic [CMP_W-1:0] cmp_a;
	logic [CMP_W-1:0] cmp_b;
	logic             cmp_ge;
	logic [CMP_W-1:0] cmp_diff;
	logic             div_first;
	logic             out_fire;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[0];
			end else if (cfg_index == REG_LIMIT) begin
				limit_q <= cfg_data[IDX_W-1:0];
			end
		end
	end

	assign stop = (limit_q < MaxCoeffs) ? limit_q : MaxCoeffs;

	assign s_tready = (state_q == S_IDLE);
	assign out_fire = (state_q == S_OUT) && (!out_valid_q || m_tready);

	assign acc_ctrl.take  = s_tready && s_tvalid;
	assign acc_ctrl.add   = (state_q == S_ADD);
	assign acc_ctrl.sq_c0 = (state_q == S_ADD) && last_q;
	assign acc_ctrl.clear = out_fire;

	gfa_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (acc_ctrl),
		.coefficient(s_tdata),
		.stop       (stop),
		.sum        (sum),
		.square     (square)
	);

	// operand select for the shared subtractor
	assign div_first = (cnt_q == DIV_STEPS_M1);

	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		unique case (state_q)
			S_PREP: begin
				cmp_a = {1'b0, sum};
				cmp_b = {{(CMP_W-SQ_W){1'b0}}, square};
			end
			S_DIV: begin
				cmp_a = div_first ? {1'b0, rem_q} : {rem_q, 1'b0};
				cmp_b = {1'b0, sum};
			end
			S_SQRT: begin
				// remainder with the next two radicand bits against 4*root + 1
				cmp_a = {{(CMP_W-VAL_W-2){1'b0}}, rem_q[VAL_W-1:0], x_q[XR_W-1 -: 2]};
				cmp_b = {{(CMP_W-VAL_W-2){1'b0}}, root_q, 2'b01};
			end
			default: begin
				cmp_a = '0;
				cmp_b = '0;
			end
		endcase
	end

	gfa_sub_unit u_sub (
		.a   (cmp_a),
		.b   (cmp_b),
		.ge  (cmp_ge),
		.diff(cmp_diff)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						last_q  <= s_tlast;
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= last_q ? S_PREP : S_IDLE;
				end
				S_PREP: begin
					if (sum == '0) begin
						state_q <= S_OUT;
					end else if (mode_q) begin
						cnt_q   <= SQRT_STEPS_M1;
						state_q <= S_SQRT;
					end else begin
						cnt_q   <= DIV_STEPS_M1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						cnt_q   <= SQRT_STEPS_M1;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= S_OUT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_OUT: begin
					if (out_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// divide and square root datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_PREP: begin
				zero_q <= (sum == '0);
				root_q <= '0;
				if (mode_q) begin
					x_q   <= {sum, {(XR_W-SUM_W){1'b0}}};
					rem_q <= '0;
				end else begin
					// numerator is sum - c0^2, floored at zero
					x_q   <= '0;
					rem_q <= cmp_ge ? cmp_diff[SUM_W-1:0] : '0;
				end
			end
			S_DIV: begin
				if (cnt_q == '0) begin
					rem_q <= '0;
				end else begin
					rem_q <= cmp_ge ? cmp_diff[SUM_W-1:0] : cmp_a[SUM_W-1:0];
				end
				// quotient bits collect at the bottom of the radicand register
				x_q   <= {x_q[XR_W-2:0], cmp_ge};
			end
			S_SQRT: begin
				rem_q  <= cmp_ge ? cmp_diff[SUM_W-1:0] : cmp_a[SUM_W-1:0];
				root_q <= {root_q[VAL_W-2:0], cmp_ge};
				x_q    <= {x_q[XR_W-3:0], 2'b00};
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			out_value_q <= zero_q ? '0 : root_q;
			out_zero_q  <= zero_q;
		end
	end

	assign m_tdata  = out_value_q;
	assign m_tuser  = out_zero_q;
	assign m_tvalid = out_valid_q;

endmodule

// File: test/gfa_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_result_checker
// Watches the coefficient, result and register channels of the anisotropy
// block. It keeps its own copy of the voxel state and the registers, predicts
// one result per closed voxel and compares each result word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module gfa_result_checker #(
	parameter int MAX_COEFFS = 45
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [gfa_pkg::COEF_W-1:0]     s_tdata,
	input  logic                           s_tlast,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [gfa_pkg::VAL_W-1:0]      m_tdata,
	input  logic                           m_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [gfa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gfa_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             pending,
	output int                             voxels_checked
);

	import gfa_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             energy_zero;
	} voxel_result_t;

	voxel_result_t    expected_results[$];

	logic             norm_mode;
	logic [IDX_W-1:0] coeff_limit;
	logic [SUM_W-1:0] energy;
	logic [COEF_W-1:0] c0_raw;
	logic [IDX_W-1:0] coef_count;

	function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int k = 31; k >= 0; k--) begin
			trial = root | (32'd1 << k);
			if (64'(trial) * 64'(trial) <= x)
				root = trial;
		end
		return root;
	endfunction

	function automatic voxel_result_t voxel_result(input logic [SUM_W-1:0] sum,
			input logic [COEF_W-1:0] first_raw, input logic norm);
		voxel_result_t    r;
		logic signed [31:0] c0s;
		logic [SUM_W-1:0] c0sq;
		logic [SUM_W-1:0] num;
		logic [71:0]      scaled;
		logic [63:0]      ratio;
		logic [31:0]      root;
		r = '0;
		if (sum == '0) begin
			r.energy_zero = 1'b1;
			return r;
		end
		if (!norm) begin
			// 1 - c0^2/sum scaled by 2^32, then the root gives Q8.16
			c0s = $signed(first_raw);
			c0sq = SUM_W'(c0s * c0s);
			num = (c0sq <= sum) ? sum - c0sq : '0;
			scaled = {num, 32'd0};
			ratio = 64'(scaled / 72'(sum));
			root = floor_sqrt(ratio);
		end else begin
			root = floor_sqrt({16'd0, sum, 8'd0});
		end
		r.value = (root > 32'h00FF_FFFF) ? '1 : root[VAL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [31:0] c;
		logic [IDX_W-1:0]   stop;
		voxel_result_t      want;
		if (!arst_n) begin
			expected_results.delete();
			norm_mode = 1'b0;
			coeff_limit = LIMIT_RESET;
			energy = '0;
			c0_raw = '0;
			coef_count = '0;
			mismatches = 0;
			pending = 0;
			voxels_checked = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MODE)
					norm_mode = cfg_data[0];
				else if (cfg_index == REG_LIMIT)
					coeff_limit = cfg_data[IDX_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				stop = (coeff_limit < MAX_COEFFS) ? coeff_limit : IDX_W'(MAX_COEFFS);
				c = $signed(s_tdata);
				if (coef_count == '0)
					c0_raw = s_tdata;
				if (coef_count < stop)
					energy = energy + SUM_W'(c * c);
				// count keeps going past the limit but sticks at the top
				if (coef_count < IDX_MAX)
					coef_count = coef_count + 1'b1;
				if (s_tlast) begin
					expected_results.push_back(voxel_result(energy, c0_raw, norm_mode));
					energy = '0;
					c0_raw = '0;
					coef_count = '0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word value=%h energy_zero=%b",
						$time, m_tdata, m_tuser);
				end else begin
					want = expected_results.pop_front();
					voxels_checked++;
					if (m_tdata !== want.value || m_tuser !== want.energy_zero) begin
						mismatches++;
						$display("%0t: expected value=%h energy_zero=%b, actual value=%h energy_zero=%b",
							$time, want.value, want.energy_zero, m_tdata, m_tuser);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: test/gfa_from_sh_coefficients_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfa_from_sh_coefficients_tb
// Drives voxels of harmonic coefficients through the anisotropy block under
// several register settings and idle/stall patterns; the checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module gfa_from_sh_coefficients_tb;

	import gfa_pkg::*;

	localparam int MAX_COEFFS    = 45;
	localparam int SETTLE_CYCLES = 100;
	localparam int LIMIT_CYCLES  = 500000;
	localparam int ITEMS_PER_SET = 100;

	// register indexes that select nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [COEF_W-1:0]     s_tdata = '0;     // coefficient
	logic                  s_tlast = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VAL_W-1:0]      m_tdata;          // value
	logic                  m_tuser;          // energy_zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int pending;
	int voxels_checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int coefs_sent = 0;
	int writes_done = 0;
	int cycles = 0;

	gfa_from_sh_coefficients #(
		.MAX_COEFFS(MAX_COEFFS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gfa_result_checker #(
		.MAX_COEFFS(MAX_COEFFS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.voxels_checked(voxels_checked)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// valid stays high between back-to-back words and only drops on a gap
	task automatic send_coef(input logic [COEF_W-1:0] coef, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= coef;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		coefs_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		writes_done++;
	endtask

	// drain all results, then give an open voxel time to finish its adds
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COEF_W-1:0] random_coef();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			3: return COEF_W'($urandom_range(31)) - 16'd16;
			default: return COEF_W'($urandom);
		endcase
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(39);
		if (r == 0)
			return $urandom_range(135, 120);
		else if (r < 6)
			return $urandom_range(3, 1);
		return $urandom_range(50, 4);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_limit(input int k);
		case (k % 6)
			0: return 8'd0;
			1: return {1'b0, LIMIT_RESET};
			2: return 8'hC0;
			3: return 8'd1;
			4: return {1'($urandom), 7'($urandom_range(44, 2))};
			default: return {1'($urandom), 7'($urandom_range(64, 46))};
		endcase
	endfunction

	task automatic send_voxel(input int len);
		for (int i = 0; i < len; i++)
			send_coef(random_coef(), i == len - 1);
	endtask

	initial begin
		int target;
		int k;
		int idle_set[4];
		int stall_set[4];
		idle_set = '{0, 56, 0, 17};
		stall_set = '{0, 0, 56, 17};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// reset settings: gfa, 45 coefficients
		send_coef(16'h7FFF, 1'b0);
		send_coef(16'h8000, 1'b1);
		// lone coefficient: all energy in c0, gfa is zero
		send_coef(16'h8000, 1'b1);
		// zero energy
		send_coef(16'h0000, 1'b1);
		send_coef(16'h1000, 1'b0);
		send_coef(16'h0000, 1'b0);
		send_coef(16'hFFFF, 1'b1);
		settle();
		write_reg(REG_MODE, 8'hFF);
		send_coef(16'h8000, 1'b0);
		send_coef(16'h7FFF, 1'b0);
		send_coef(16'h8000, 1'b1);
		send_coef(16'h0000, 1'b0);
		send_coef(16'h0000, 1'b1);
		settle();
		// limit zero: nothing summed
		write_reg(REG_LIMIT, 8'd0);
		send_coef(16'h1234, 1'b0);
		send_coef(16'h7FFF, 1'b1);
		settle();
		write_reg(REG_MODE, 8'h00);
		send_coef(16'h8000, 1'b1);
		settle();
		write_reg(REG_LIMIT, 8'd1);
		send_coef(16'h4000, 1'b0);
		send_coef(16'hFFFF, 1'b0);
		send_coef(16'h0001, 1'b1);
		settle();
		// limit above the maximum, then registers change inside an open voxel
		write_reg(REG_LIMIT, 8'hC0);
		send_coef(16'h2000, 1'b0);
		send_coef(16'hE000, 1'b0);
		settle();
		write_reg(REG_MODE, 8'h01);
		write_reg(REG_LIMIT, 8'd2);
		send_coef(16'h7FFF, 1'b0);
		send_coef(16'h7FFF, 1'b1);
		settle();
		write_reg(REG_SPARE_A, 8'hA5);
		write_reg(REG_SPARE_B, 8'h5A);

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			for (int s = 0; s < 3; s++) begin
				k = p * 3 + s;
				settle();
				write_reg(REG_MODE, CFG_DATA_W'($urandom));
				write_reg(REG_LIMIT, pick_limit(k));
				target = coefs_sent + ITEMS_PER_SET;
				while (coefs_sent < target)
					send_voxel(pick_length());
				// sometimes leave the voxel open across the register writes
				if ($urandom_range(2) == 0)
					repeat ($urandom_range(5, 1)) send_coef(random_coef(), 1'b0);
			end
		end
		send_coef(random_coef(), 1'b1);
		settle();

		$display("covered %0d coefficients, %0d voxel results, %0d register writes",
			coefs_sent, voxels_checked, writes_done);
		$display("both modes, limits from zero to above the maximum, four idle/stall mixes");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: gfa_from_sh_coefficients.f
rtl/gfa_pkg.sv
rtl/gfa_sub_unit.sv
rtl/gfa_accum.sv
rtl/gfa_from_sh_coefficients.sv
test/gfa_result_checker.sv
test/gfa_from_sh_coefficients_tb.sv
